// ===== rtl/lea128_pkg.sv =====
`default_nettype none

package lea128_pkg;

   // Datapath and config sizes
   localparam int WORD_W      = 32;
   localparam int KEY_WORDS   = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int ROUNDS_DEF  = 24;
   localparam int ROT_W       = 5;

   // Four 32-bit words of one block or one round key, element 0 is word 0
   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] word4_type;

   // Key schedule constants, element 0 is the first delta
   localparam logic [3:0][WORD_W-1:0] DELTA = {
      32'h78DF30EC, 32'h79E27C8A, 32'h44626B02, 32'hC3EFE9DB
   };

   // Per-word rotate amounts of the key schedule
   localparam logic [3:0][ROT_W-1:0] KS_ROT = {5'd11, 5'd6, 5'd3, 5'd1};

   // Rotate left; a zero amount passes the word through
   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input logic [ROT_W-1:0] n);
      logic [ROT_W:0] m;
      m = 6'd32 - {1'b0, n};
      if (n == '0) begin
         return x;
      end
      return (x << n) | (x >> m);
   endfunction

   // Delta of round r, rotated by r + j
   function automatic logic [WORD_W-1:0] delta_rot(input logic [ROT_W-1:0] r,
                                                   input logic [1:0] j);
      logic [ROT_W-1:0] amt;
      amt = r + {3'b000, j};
      return rotl(DELTA[r[1:0]], amt);
   endfunction

   // One encryption round
   function automatic word4_type fwd_round(input word4_type x, input word4_type k);
      word4_type y;
      y[0] = rotl((x[0] ^ k[0]) + (x[1] ^ k[1]), 5'd9);
      y[1] = rotl((x[1] ^ k[2]) + (x[2] ^ k[1]), 5'd5);
      y[2] = rotl((x[2] ^ k[3]) + (x[3] ^ k[1]), 5'd3);
      y[3] = x[0];
      return y;
   endfunction

   // One decryption round (inverse of fwd_round with the same key)
   function automatic word4_type inv_round(input word4_type x, input word4_type k);
      word4_type y;
      y[0] = x[3];
      y[1] = (rotl(x[0], 5'd23) - (y[0] ^ k[0])) ^ k[1];
      y[2] = (rotl(x[1], 5'd27) - (y[1] ^ k[2])) ^ k[1];
      y[3] = (rotl(x[2], 5'd29) - (y[2] ^ k[3])) ^ k[1];
      return y;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lea128_block_cipher.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Word
// req     | in        | req_valid/req_ready  | req_type, req_in_word_0..3
// rsp     | out       | rsp_valid/rsp_ready  | rsp_out_word_0..3
// csr     | in        | csr_wr_en            | csr_index, csr_wr_data (key words)
//
// An accepted word moves through the round pipeline, one pipeline stage per round,
// and shows on rsp_valid once it reaches the last stage.
// Throughput is one word per cycle while rsp_ready holds and no key schedule runs; the round pipeline sets it.
// After reset and after any key write the key schedule computes one round key per cycle
// until all ROUNDS round keys are done, and req_ready stays low meanwhile.
// Each stage holds its word while the next one is full and blocked; empty
// stages close up, so no word is lost or repeated under stalls.

module lea128_block_cipher #(
   parameter int ROUNDS = lea128_pkg::ROUNDS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // request
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_type,
   input  wire [lea128_pkg::WORD_W-1:0]     req_in_word_0,
   input  wire [lea128_pkg::WORD_W-1:0]     req_in_word_1,
   input  wire [lea128_pkg::WORD_W-1:0]     req_in_word_2,
   input  wire [lea128_pkg::WORD_W-1:0]     req_in_word_3,
   // response
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [lea128_pkg::WORD_W-1:0]    rsp_out_word_0,
   output logic [lea128_pkg::WORD_W-1:0]    rsp_out_word_1,
   output logic [lea128_pkg::WORD_W-1:0]    rsp_out_word_2,
   output logic [lea128_pkg::WORD_W-1:0]    rsp_out_word_3,
   // config
   input  wire                              csr_wr_en,
   input  wire [lea128_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [lea128_pkg::WORD_W-1:0]     csr_wr_data
);

   localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   // Key registers and key schedule state
   lea128_pkg::word4_type key_ff;
   lea128_pkg::word4_type t_ff;
   lea128_pkg::word4_type t_in;
   lea128_pkg::word4_type t_src;
   logic                  kx_busy_ff;
   logic [RND_W-1:0]      kx_cnt_ff;

   // Round key registers, one row per round
   lea128_pkg::word4_type rk_ff [ROUNDS];

   // Pipeline stages
   lea128_pkg::word4_type dat_ff [ROUNDS];
   logic                  dec_ff [ROUNDS];
   logic                  vld_ff [ROUNDS];
   logic                  stg_rdy [ROUNDS+1];

   // Key words: written from the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff[csr_index] <= csr_wr_data;
      end
   end

   // Key schedule step: round key of round kx_cnt_ff
   always_comb begin
      t_src = (kx_cnt_ff == '0) ? key_ff : t_ff;
      for (int j = 0; j < lea128_pkg::KEY_WORDS; j++) begin
         t_in[j] = lea128_pkg::rotl(
            t_src[j] + lea128_pkg::delta_rot(lea128_pkg::ROT_W'(kx_cnt_ff), 2'(j)),
            lea128_pkg::KS_ROT[j]);
      end
   end

   // Schedule control: restarts on every key write
   always_ff @(posedge clock) begin
      if (reset) begin
         kx_busy_ff <= 1'b1;
         kx_cnt_ff  <= '0;
      end else if (csr_wr_en) begin
         kx_busy_ff <= 1'b1;
         kx_cnt_ff  <= '0;
      end else if (kx_busy_ff) begin
         if (kx_cnt_ff == RND_W'(ROUNDS - 1)) begin
            kx_busy_ff <= 1'b0;
            kx_cnt_ff  <= '0;
         end else begin
            kx_cnt_ff  <= kx_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (kx_busy_ff) begin
         t_ff <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      if (kx_busy_ff && !csr_wr_en) begin
         rk_ff[kx_cnt_ff] <= t_in;
      end
   end

   // Handshake
   assign req_ready        = !kx_busy_ff && stg_rdy[0];
   assign stg_rdy[ROUNDS]  = rsp_ready;

   // Round pipeline: stage s runs round s (encrypt) or round ROUNDS-1-s (decrypt)
   for (genvar s = 0; s < ROUNDS; s++) begin : g_stage
      lea128_pkg::word4_type src;
      lea128_pkg::word4_type key;
      lea128_pkg::word4_type dat_in;
      logic                  src_dec;
      logic                  vld_in;

      if (s == 0) begin : g_head
         assign src[0]  = req_in_word_0;
         assign src[1]  = req_in_word_1;
         assign src[2]  = req_in_word_2;
         assign src[3]  = req_in_word_3;
         assign src_dec = req_type;
         assign vld_in  = req_valid && !kx_busy_ff;
      end else begin : g_body
         assign src     = dat_ff[s-1];
         assign src_dec = dec_ff[s-1];
         assign vld_in  = vld_ff[s-1];
      end

      assign key    = src_dec ? rk_ff[ROUNDS-1-s] : rk_ff[s];
      assign dat_in = src_dec ? lea128_pkg::inv_round(src, key)
                              : lea128_pkg::fwd_round(src, key);

      // stage may load when empty or when its word moves on
      assign stg_rdy[s] = !vld_ff[s] || stg_rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (stg_rdy[s]) begin
            vld_ff[s] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (stg_rdy[s]) begin
            dat_ff[s] <= dat_in;
            dec_ff[s] <= src_dec;
         end
      end
   end

   // Response from the last stage
   assign rsp_valid      = vld_ff[ROUNDS-1];
   assign rsp_out_word_0 = dat_ff[ROUNDS-1][0];
   assign rsp_out_word_1 = dat_ff[ROUNDS-1][1];
   assign rsp_out_word_2 = dat_ff[ROUNDS-1][2];
   assign rsp_out_word_3 = dat_ff[ROUNDS-1][3];

   // Checks
   a_kx_restart: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> kx_busy_ff && (kx_cnt_ff == '0))
      else $error("key schedule did not restart after key write");

   a_kx_done: assert property (@(posedge clock) disable iff (reset)
      $fell(kx_busy_ff) |-> ($past(kx_cnt_ff) == RND_W'(ROUNDS - 1)))
      else $error("key schedule ended early");

   a_kx_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      !kx_busy_ff |-> (kx_cnt_ff == '0))
      else $error("schedule counter moved while idle");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$past(kx_busy_ff) && vld_ff[0])
      else $error("word accepted during key schedule or lost at stage 0");

endmodule

`default_nettype wire

// ===== dv/lea128_cipher_checker.sv =====
`timescale 1ns / 100ps

// Codes shared by the testbench top and the checker
package lea128_tb_pkg;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } lea_op_type;

   typedef enum logic [1:0] {
      CSR_KEY_WORD_0 = 2'd0,
      CSR_KEY_WORD_1 = 2'd1,
      CSR_KEY_WORD_2 = 2'd2,
      CSR_KEY_WORD_3 = 2'd3
   } lea_csr_type;

endpackage

// Watches the req, rsp and csr ports, predicts every block and compares
// each returned word against the oldest prediction.
module lea128_cipher_checker #(
   parameter int ROUNDS = lea128_pkg::ROUNDS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire         req_type,
   input  wire [31:0]  req_in_word_0,
   input  wire [31:0]  req_in_word_1,
   input  wire [31:0]  req_in_word_2,
   input  wire [31:0]  req_in_word_3,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire [31:0]  rsp_out_word_0,
   input  wire [31:0]  rsp_out_word_1,
   input  wire [31:0]  rsp_out_word_2,
   input  wire [31:0]  rsp_out_word_3,
   input  wire         csr_wr_en,
   input  wire [1:0]   csr_index,
   input  wire [31:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_blocks,
   output int          result_count
);

   typedef struct {
      int unsigned           seq;
      lea128_pkg::word4_type blk;
   } cipher_expect_type;

   cipher_expect_type     expected_blocks[$];
   lea128_pkg::word4_type key_words;
   lea128_pkg::word4_type round_keys[ROUNDS];
   bit                    schedule_stale;
   int                    mismatches;
   int                    results_seen;
   int unsigned           accepted_blocks;

   initial begin
      fail_count     = 0;
      pending_blocks = 0;
      result_count   = 0;
   end

   // rotate left, amount taken mod 32; zero comes out as the identity
   function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
      logic [63:0] dbl;
      dbl = {x, x} << (n % 32);
      return dbl[63:32];
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
      return rol(x, 32 - (n % 32));
   endfunction

   // key schedule: four running words, one round key per round
   function automatic void expand_schedule();
      lea128_pkg::word4_type t;
      t = key_words;
      for (int r = 0; r < ROUNDS; r++) begin
         for (int j = 0; j < 4; j++) begin
            t[j] = rol(t[j] + rol(lea128_pkg::DELTA[r % 4], r + j), lea128_pkg::KS_ROT[j]);
         end
         round_keys[r] = t;
      end
      schedule_stale = 1'b0;
   endfunction

   // full encrypt or decrypt of one block with the current round keys
   function automatic lea128_pkg::word4_type lea_crypt(input lea128_tb_pkg::lea_op_type op,
                                                       input lea128_pkg::word4_type blk);
      lea128_pkg::word4_type x;
      lea128_pkg::word4_type y;
      lea128_pkg::word4_type k;
      x = blk;
      if (op == lea128_tb_pkg::OP_ENCRYPT) begin
         for (int r = 0; r < ROUNDS; r++) begin
            k = round_keys[r];
            y[0] = rol((x[0] ^ k[0]) + (x[1] ^ k[1]), 9);
            y[1] = rol((x[1] ^ k[2]) + (x[2] ^ k[1]), 5);
            y[2] = rol((x[2] ^ k[3]) + (x[3] ^ k[1]), 3);
            y[3] = x[0];
            x = y;
         end
      end else begin
         for (int r = ROUNDS - 1; r >= 0; r--) begin
            k = round_keys[r];
            y[0] = x[3];
            y[1] = (ror(x[0], 9) - (y[0] ^ k[0])) ^ k[1];
            y[2] = (ror(x[1], 5) - (y[1] ^ k[2])) ^ k[1];
            y[3] = (ror(x[2], 3) - (y[2] ^ k[3])) ^ k[1];
            x = y;
         end
      end
      return x;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned seq,
                                  input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("[%0t] block %0d %s: got %08h, want %08h", $time, seq, what, got, want);
      end
   endtask

   always @(posedge clock) begin : watch
      cipher_expect_type     want;
      lea128_pkg::word4_type got;
      lea128_pkg::word4_type blk;
      if (reset) begin
         expected_blocks.delete();
         key_words      = '0;
         schedule_stale = 1'b1;
      end else begin
         // returned word against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got = {rsp_out_word_3, rsp_out_word_2, rsp_out_word_1, rsp_out_word_0};
            if (expected_blocks.size() == 0) begin
               report_mismatch("result with nothing pending, out_word_0", results_seen,
                               got[0], '0);
            end else begin
               want = expected_blocks.pop_front();
               for (int i = 0; i < 4; i++) begin
                  if (got[i] !== want.blk[i]) begin
                     report_mismatch($sformatf("out_word_%0d", i), want.seq, got[i],
                                     want.blk[i]);
                  end
               end
            end
         end
         // key write marks the schedule for re-expansion
         if (csr_wr_en) begin
            key_words[csr_index] = csr_wr_data;
            schedule_stale       = 1'b1;
         end
         // accepted block: predict its result
         if (req_valid && req_ready) begin
            if (schedule_stale) begin
               expand_schedule();
            end
            blk = {req_in_word_3, req_in_word_2, req_in_word_1, req_in_word_0};
            want.seq = accepted_blocks;
            want.blk = lea_crypt(lea128_tb_pkg::lea_op_type'(req_type), blk);
            expected_blocks.push_back(want);
            accepted_blocks++;
         end
      end
      pending_blocks <= expected_blocks.size();
      fail_count     <= mismatches;
      result_count   <= results_seen;
   end

endmodule

// ===== dv/tb_lea128_block_cipher.sv =====
`timescale 1ns / 100ps

module tb_lea128_block_cipher;

   localparam int ROUNDS        = lea128_pkg::ROUNDS_DEF;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BLOCKS  = 110;
   localparam int RUN_LIMIT_NS  = 5_000_000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_type       = 1'b0;
   logic [31:0] req_in_word_0  = '0;
   logic [31:0] req_in_word_1  = '0;
   logic [31:0] req_in_word_2  = '0;
   logic [31:0] req_in_word_3  = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_out_word_0;
   logic [31:0] rsp_out_word_1;
   logic [31:0] rsp_out_word_2;
   logic [31:0] rsp_out_word_3;
   logic        csr_wr_en      = 1'b0;
   logic [1:0]  csr_index      = '0;
   logic [31:0] csr_wr_data    = '0;

   int fail_count;
   int pending_blocks;
   int result_count;

   bit tx_idle_en = 1'b0;
   bit rx_idle_en = 1'b0;
   int hold_ask   = 0;
   int sent_blocks;
   int sent_decrypt;
   int key_loads;

   lea128_block_cipher #(.ROUNDS(ROUNDS)) dut (.*);

   lea128_cipher_checker #(.ROUNDS(ROUNDS)) chk (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned gap_cycles();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return $urandom_range(3, 1);
      if (pick < 95) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // corner patterns mixed with fully random words
   function automatic logic [31:0] pattern_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(31);
         3: return ~(32'h1 << $urandom_range(31));
         default: return $urandom();
      endcase
   endfunction

   function automatic lea128_pkg::word4_type random_block();
      return {pattern_word(), pattern_word(), pattern_word(), pattern_word()};
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   initial begin : receiver
      int hold_seen;
      int stall_left;
      hold_seen  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!rx_idle_en) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(99) < 25) stall_left = gap_cycles();
         end
      end
   end

   // offer one block, hold it until taken, then maybe idle
   task automatic send_block(input lea128_tb_pkg::lea_op_type op,
                             input lea128_pkg::word4_type blk);
      int unsigned gap;
      req_valid     <= 1'b1;
      req_type      <= op;
      req_in_word_0 <= blk[0];
      req_in_word_1 <= blk[1];
      req_in_word_2 <= blk[2];
      req_in_word_3 <= blk[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_blocks++;
      if (op == lea128_tb_pkg::OP_DECRYPT) sent_decrypt++;
      gap = (tx_idle_en && $urandom_range(1)) ? gap_cycles() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every pending result
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_blocks != 0);
   endtask

   task automatic csr_write(input lea128_tb_pkg::lea_csr_type idx, input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   // key change only on an idle block; mask picks the registers written
   task automatic load_key(input logic [3:0] mask, input lea128_pkg::word4_type k);
      wait_idle();
      repeat (ROUNDS + 4) @(posedge clock);
      if (mask[0]) csr_write(lea128_tb_pkg::CSR_KEY_WORD_0, k[0]);
      if (mask[1]) csr_write(lea128_tb_pkg::CSR_KEY_WORD_1, k[1]);
      if (mask[2]) csr_write(lea128_tb_pkg::CSR_KEY_WORD_2, k[2]);
      if (mask[3]) csr_write(lea128_tb_pkg::CSR_KEY_WORD_3, k[3]);
      csr_wr_en <= 1'b0;
      key_loads++;
   endtask

   initial begin : stimulus
      lea128_pkg::word4_type      patterns[6];
      lea128_tb_pkg::lea_op_type  op;
      patterns[0] = '0;
      patterns[1] = '1;
      patterns[2] = {4{32'h5555_5555}};
      patterns[3] = {4{32'hAAAA_AAAA}};
      patterns[4] = {32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001};
      patterns[5] = {32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset key (all zero), expanded on first use
      foreach (patterns[i]) begin
         send_block(lea128_tb_pkg::OP_ENCRYPT, patterns[i]);
         send_block(lea128_tb_pkg::OP_DECRYPT, patterns[i]);
      end

      // all-ones key
      load_key(4'hF, '1);
      send_block(lea128_tb_pkg::OP_ENCRYPT, '1);
      send_block(lea128_tb_pkg::OP_DECRYPT, '0);

      // published test vector, both directions
      load_key(4'hF, {32'hF0E1D2C3, 32'hB4A59687, 32'h78695A4B, 32'h3C2D1E0F});
      send_block(lea128_tb_pkg::OP_ENCRYPT,
                 {32'h1F1E1D1C, 32'h1B1A1918, 32'h17161514, 32'h13121110});
      send_block(lea128_tb_pkg::OP_DECRYPT,
                 {32'hFD8B6404, 32'hA7C73255, 32'h18C6C628, 32'h354EC89F});

      // single key word changed between blocks
      load_key(4'b0100, {32'h0, 32'hDEAD_BEEF, 32'h0, 32'h0});
      send_block(lea128_tb_pkg::OP_ENCRYPT,
                 {32'h1F1E1D1C, 32'h1B1A1918, 32'h17161514, 32'h13121110});
      send_block(lea128_tb_pkg::OP_DECRYPT,
                 {32'hFD8B6404, 32'hA7C73255, 32'h18C6C628, 32'h354EC89F});

      // random phases, each with its own key and idle pattern
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_key((p == 0) ? 4'hF : 4'($urandom_range(15, 1)), random_block());
         tx_idle_en = (p % 4 == 0) || (p % 4 == 2);
         rx_idle_en = (p % 4 == 0) || (p % 4 == 3);
         // long output hold-off while blocks keep coming back to back
         if (p % 4 == 3) hold_ask++;
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            if (p == 5 && n == PHASE_BLOCKS / 2) wait_idle();
            op = lea128_tb_pkg::lea_op_type'($urandom_range(1));
            send_block(op, random_block());
         end
      end

      wait_idle();
      repeat (2 * ROUNDS) @(posedge clock);

      $display("Ran %0d blocks (%0d decrypt) over %0d key loads, %0d results checked.",
               sent_blocks, sent_decrypt, key_loads, result_count);
      $display("Covered reset, all-ones and partial key changes, a %0d-cycle output hold-off.",
               HOLD_CYCLES);
      if (fail_count == 0 && pending_blocks == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== lea128_block_cipher.f =====
rtl/lea128_pkg.sv
rtl/lea128_block_cipher.sv
dv/lea128_cipher_checker.sv
dv/tb_lea128_block_cipher.sv
